/* design/ascon_xs_pkg.sv */
package ascon_xs_pkg;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned NUM_WORDS   = 5;
    localparam int unsigned MAX_ROUNDS  = 12;
    localparam int unsigned ROUNDS_INIT  = 12;
    localparam int unsigned ROUNDS_BLOCK = 8;

    localparam logic [WORD_W-1:0] XOF_IV   = 64'h0040_0c00_0000_0000;
    localparam logic [7:0]        PAD_BYTE = 8'h80;

    localparam logic [3:0] FIRST_INIT  = 4'(MAX_ROUNDS - ROUNDS_INIT);
    localparam logic [3:0] FIRST_BLOCK = 4'(MAX_ROUNDS - ROUNDS_BLOCK);
    localparam logic [3:0] LAST_ROUND  = 4'(MAX_ROUNDS - 1);

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [NUM_WORDS-1:0] t_sponge;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_ABSORB  = 2'd1,
        MODE_FINAL   = 2'd2,
        MODE_SQUEEZE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_EMIT
    } t_state;

    function automatic t_word rotr(input t_word v, input int unsigned n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

    function automatic t_word pad_block(input t_word data, input logic [2:0] count);
        t_word blk;
        blk = '0;
        for (int k = 0; k < 8; k++) begin
            if (k < int'(count)) begin
                blk[WORD_W-1-8*k -: 8] = data[WORD_W-1-8*k -: 8];
            end else if (k == int'(count)) begin
                blk[WORD_W-1-8*k -: 8] = PAD_BYTE;
            end
        end
        return blk;
    endfunction

    function automatic t_sponge ascon_round(input t_sponge w, input logic [3:0] idx);
        t_word a, b, c, d, e, t0, t1, t2, t3, t4;
        t_sponge r;
        a = w[0]; b = w[1]; c = w[2]; d = w[3]; e = w[4];
        c[7:0] = c[7:0] ^ {4'hf - idx, idx};
        a = a ^ e; e = e ^ d; c = c ^ b;
        t0 = ~a & b; t1 = ~b & c; t2 = ~c & d; t3 = ~d & e; t4 = ~e & a;
        a = a ^ t1; b = b ^ t2; c = c ^ t3; d = d ^ t4; e = e ^ t0;
        b = b ^ a; a = a ^ e; d = d ^ c; c = ~c;
        r[0] = a ^ rotr(a, 19) ^ rotr(a, 28);
        r[1] = b ^ rotr(b, 61) ^ rotr(b, 39);
        r[2] = c ^ rotr(c, 1)  ^ rotr(c, 6);
        r[3] = d ^ rotr(d, 10) ^ rotr(d, 17);
        r[4] = e ^ rotr(e, 7)  ^ rotr(e, 41);
        return r;
    endfunction

endpackage

/* design/ascon_xs_in_if.sv */
interface ascon_xs_in_if;
    import ascon_xs_pkg::*;

    logic        valid;
    logic        ready;
    t_mode       mode;
    logic [63:0] data_block;
    logic [2:0]  byte_count;

    modport source (output valid, output mode, output data_block, output byte_count,
                    input ready);
    modport sink   (input valid, input mode, input data_block, input byte_count,
                    output ready);
endinterface

/* design/ascon_xs_out_if.sv */
interface ascon_xs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_block;

    modport source (output valid, output out_block, input ready);
    modport sink   (input valid, input out_block, output ready);
endinterface

/* design/ascon_xof_sponge_top.sv */
// Ascon-XOF sponge core: one round of the permutation per clock on a single shared
// round unit. A word is taken only while the core is idle; after the accept the core runs
// 12 rounds for start and final, 8 for absorb, and for squeeze an output step plus
// 8 rounds (12 more in front when the squeeze first closes an empty final block). Absorb
// and final given while squeezing are dropped at once. The output word sits in its own
// register, so a new word is taken while it waits; only the output cycle of a squeeze
// holds until that register is free. A start is required after reset.
module ascon_xof_sponge_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ascon_xs_in_if.sink     i_in,
    ascon_xs_out_if.source  o_out
);
    import ascon_xs_pkg::*;

    t_state     r_state, n_state;
    t_sponge    r_w, n_w;
    logic [3:0] r_idx, n_idx;
    logic       r_sq, n_sq;
    logic       r_emit, n_emit;
    logic       r_out_valid, n_out_valid;
    t_word      r_out_block, n_out_block;
    logic       w_acc;

    assign i_in.ready      = (r_state == ST_IDLE);
    assign w_acc           = i_in.valid && i_in.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.out_block = r_out_block;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_w         <= '0;
            r_idx       <= '0;
            r_sq        <= 1'b0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_w         <= n_w;
            r_idx       <= n_idx;
            r_sq        <= n_sq;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
        r_out_block <= n_out_block;
    end

    always_comb begin
        n_state     = r_state;
        n_w         = r_w;
        n_idx       = r_idx;
        n_sq        = r_sq;
        n_emit      = r_emit;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_block = r_out_block;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    unique case (i_in.mode)
                        MODE_START: begin
                            n_w     = '0;
                            n_w[0]  = XOF_IV;
                            n_sq    = 1'b0;
                            n_idx   = FIRST_INIT;
                            n_state = ST_ROUND;
                        end
                        MODE_ABSORB: begin
                            if (!r_sq) begin
                                n_w[0]  = r_w[0] ^ i_in.data_block;
                                n_idx   = FIRST_BLOCK;
                                n_state = ST_ROUND;
                            end
                        end
                        MODE_FINAL: begin
                            if (!r_sq) begin
                                n_w[0]  = r_w[0] ^ pad_block(i_in.data_block, i_in.byte_count);
                                n_sq    = 1'b1;
                                n_idx   = FIRST_INIT;
                                n_state = ST_ROUND;
                            end
                        end
                        MODE_SQUEEZE: begin
                            if (r_sq) begin
                                n_state = ST_EMIT;
                            end else begin
                                n_w[0]  = r_w[0] ^ pad_block('0, 3'd0);
                                n_sq    = 1'b1;
                                n_emit  = 1'b1;
                                n_idx   = FIRST_INIT;
                                n_state = ST_ROUND;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ROUND: begin
                n_w   = ascon_round(r_w, r_idx);
                n_idx = 4'(r_idx + 4'd1);
                if (r_idx == LAST_ROUND) begin
                    n_state = r_emit ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_block = r_w[0];
                    n_emit      = 1'b0;
                    n_idx       = FIRST_BLOCK;
                    n_state     = ST_ROUND;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_emit_in_squeeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT || r_emit) |-> r_sq)
        else $error("output pending outside squeeze phase");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_EMIT)
        else $error("output word loaded outside emit step");

    a_absorb_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_sq && (i_in.mode == MODE_ABSORB || i_in.mode == MODE_FINAL))
        |=> (r_state == ST_IDLE && $stable(r_w)))
        else $error("absorb in squeeze phase changed the state");

    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_idx == LAST_ROUND && !r_emit) |=> r_state == ST_IDLE)
        else $error("sequencer did not return to idle after last round");
`endif

endmodule

/* verif/ascon_xof_sponge_top_tb.sv */
module ascon_xof_sponge_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ascon_xs_pkg::*;

    localparam int unsigned RANDOM_WORDS  = 1650;
    localparam int unsigned IDLE_LIMIT    = 4000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned HOLD_AFTER    = 300;
    localparam int unsigned DRAIN_CYCLES  = 40;
    localparam int unsigned MAX_SHOWN     = 10;
    localparam int unsigned DIR_ROWS      = 26;
    localparam t_word       ONES          = 64'hffff_ffff_ffff_ffff;

    typedef struct {
        t_mode      mode;
        t_word      data;
        logic [2:0] count;
        bit         none;
    } t_dir_row;

    // none: the word can give no output, so nothing is queued for it
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{MODE_SQUEEZE, 64'h0,                  3'd0, 1'b0},
        '{MODE_ABSORB,  ONES,                   3'd7, 1'b1},
        '{MODE_FINAL,   ONES,                   3'd7, 1'b1},
        '{MODE_SQUEEZE, ONES,                   3'd0, 1'b0},
        '{MODE_START,   ONES,                   3'd7, 1'b1},
        '{MODE_ABSORB,  64'h0,                  3'd0, 1'b1},
        '{MODE_ABSORB,  ONES,                   3'd0, 1'b1},
        '{MODE_FINAL,   ONES,                   3'd0, 1'b1},
        '{MODE_SQUEEZE, 64'h0,                  3'd0, 1'b0},
        '{MODE_SQUEEZE, 64'h0,                  3'd0, 1'b0},
        '{MODE_START,   64'h0,                  3'd0, 1'b1},
        '{MODE_FINAL,   ONES,                   3'd7, 1'b1},
        '{MODE_SQUEEZE, ONES,                   3'd7, 1'b0},
        '{MODE_START,   64'h0,                  3'd0, 1'b1},
        '{MODE_ABSORB,  64'h0123_4567_89ab_cdef, 3'd2, 1'b1},
        '{MODE_START,   64'h0,                  3'd0, 1'b1},
        '{MODE_ABSORB,  64'hfedc_ba98_7654_3210, 3'd6, 1'b1},
        '{MODE_SQUEEZE, 64'h0,                  3'd0, 1'b0},
        '{MODE_FINAL,   64'h5555_5555_5555_5555, 3'd3, 1'b1},
        '{MODE_SQUEEZE, 64'h0,                  3'd0, 1'b0},
        '{MODE_START,   64'h0,                  3'd0, 1'b1},
        '{MODE_FINAL,   64'ha5a5_a5a5_a5a5_a5a5, 3'd5, 1'b1},
        '{MODE_SQUEEZE, 64'h0,                  3'd0, 1'b0},
        '{MODE_START,   64'h0,                  3'd0, 1'b1},
        '{MODE_FINAL,   64'h8000_0000_0000_0001, 3'd1, 1'b1},
        '{MODE_SQUEEZE, 64'h0,                  3'd0, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ascon_xs_in_if  in_ch ();
    ascon_xs_out_if out_ch ();

    ascon_xof_sponge_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_word       sponge_w [NUM_WORDS];
    bit          sponge_squeezing;
    t_word       squeeze_words_q [$];
    int unsigned fail_count  = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left  = 0;
    int unsigned fed         = 0;
    bit          gen_squeezing;
    logic        row_none;
    bit          dir_done = 1'b0;

    function automatic t_word ror64(input t_word v, input int unsigned n);
        logic [2*WORD_W-1:0] twice;
        twice = {v, v} >> n;
        return twice[WORD_W-1:0];
    endfunction

    function automatic void sponge_permute(input int unsigned n);
        t_word      a, b, c, d, e, t0, t1, t2, t3, t4;
        logic [3:0] idx;
        for (int unsigned r = MAX_ROUNDS - n; r < MAX_ROUNDS; r++) begin
            idx = 4'(r);
            a = sponge_w[0]; b = sponge_w[1]; c = sponge_w[2];
            d = sponge_w[3]; e = sponge_w[4];
            c = c ^ {56'd0, 4'hf - idx, idx};
            a = a ^ e; e = e ^ d; c = c ^ b;
            t0 = ~a & b; t1 = ~b & c; t2 = ~c & d; t3 = ~d & e; t4 = ~e & a;
            a = a ^ t1; b = b ^ t2; c = c ^ t3; d = d ^ t4; e = e ^ t0;
            b = b ^ a; a = a ^ e; d = d ^ c; c = ~c;
            sponge_w[0] = a ^ ror64(a, 19) ^ ror64(a, 28);
            sponge_w[1] = b ^ ror64(b, 61) ^ ror64(b, 39);
            sponge_w[2] = c ^ ror64(c, 1)  ^ ror64(c, 6);
            sponge_w[3] = d ^ ror64(d, 10) ^ ror64(d, 17);
            sponge_w[4] = e ^ ror64(e, 7)  ^ ror64(e, 41);
        end
    endfunction

    function automatic void sponge_close(input t_word d, input logic [2:0] c);
        t_word       keep, blk;
        int unsigned sh;
        sh   = 8 * int'(c);
        keep = (sh == 0) ? t_word'(0) : (ONES << (WORD_W - sh));
        blk  = (d & keep) | (t_word'(PAD_BYTE) << (56 - sh));
        sponge_w[0] = sponge_w[0] ^ blk;
        sponge_permute(ROUNDS_INIT);
        sponge_squeezing = 1'b1;
    endfunction

    function automatic bit sponge_apply(input t_mode m, input t_word d, input logic [2:0] c,
                                        output t_word word);
        word = '0;
        case (m)
            MODE_START: begin
                sponge_w[0] = XOF_IV;
                for (int k = 1; k < NUM_WORDS; k++) sponge_w[k] = '0;
                sponge_squeezing = 1'b0;
                sponge_permute(ROUNDS_INIT);
            end
            MODE_ABSORB: begin
                if (!sponge_squeezing) begin
                    sponge_w[0] = sponge_w[0] ^ d;
                    sponge_permute(ROUNDS_BLOCK);
                end
            end
            MODE_FINAL: begin
                if (!sponge_squeezing) sponge_close(d, c);
            end
            default: begin
                if (!sponge_squeezing) sponge_close('0, 3'd0);
                word = sponge_w[0];
                sponge_permute(ROUNDS_BLOCK);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_word got_word;
        t_word want_word;
        if (out_ch.valid && out_ch.ready) begin
            if (squeeze_words_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("unexpected out_block %h", out_ch.out_block);
            end else begin
                want_word = squeeze_words_q.pop_front();
                if (out_ch.out_block !== want_word) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("out_block mismatch: expected %h, got %h",
                                 want_word, out_ch.out_block);
                end
            end
        end
        if (in_ch.valid && in_ch.ready) begin
            if (sponge_apply(in_ch.mode, in_ch.data_block, in_ch.byte_count, got_word)
                && !row_none)
                squeeze_words_q.push_back(got_word);
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ascon_xof_sponge_top_tb failed");
                $finish;
            end
        end
    end

    function automatic t_word rand_word();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return '0;
        if (pick == 1) return ONES;
        return {$urandom(), $urandom()};
    endfunction

    task automatic feed(input t_mode m, input t_word d, input logic [2:0] c,
                        input bit none = 1'b0);
        bit dropped;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= m;
        in_ch.data_block <= d;
        in_ch.byte_count <= c;
        row_none         <= none;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        dropped = gen_squeezing && (m == MODE_ABSORB || m == MODE_FINAL);
        if (m == MODE_START) gen_squeezing = 1'b0;
        else if (m != MODE_ABSORB) gen_squeezing = 1'b1;
        if (!dropped) fed++;
    endtask

    task automatic random_message();
        int unsigned pick, n_abs, n_sq;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            feed(t_mode'($urandom_range(0, 3)), rand_word(), 3'($urandom_range(0, 7)));
            return;
        end
        feed(MODE_START, rand_word(), 3'($urandom_range(0, 7)));
        n_abs = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
        repeat (n_abs) feed(MODE_ABSORB, rand_word(), 3'($urandom_range(0, 7)));
        if (pick < 14) return;
        if ($urandom_range(0, 4) != 0)
            feed(MODE_FINAL, rand_word(), 3'($urandom_range(0, 7)));
        n_sq = $urandom_range(1, 4);
        for (int unsigned k = 0; k < n_sq; k++) begin
            feed(MODE_SQUEEZE, rand_word(), 3'($urandom_range(0, 7)));
            if (pick < 22 && k == 0)
                feed($urandom_range(0, 1) ? MODE_ABSORB : MODE_FINAL, rand_word(),
                     3'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        int unsigned style, span, tick;
        bit          held;
        out_ch.ready <= 1'b0;
        held = 1'b0;
        tick = 0;
        repeat (10) @(posedge i_clk);
        forever begin
            if (!held && fed >= HOLD_AFTER && dir_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end else begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(20, 200);
                repeat (span) begin
                    case (style)
                        0:       out_ch.ready <= 1'b1;
                        1:       out_ch.ready <= 1'($urandom_range(0, 1));
                        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                        default: out_ch.ready <= ((tick % 5) < 3);
                    endcase
                    tick++;
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        in_ch.valid      <= 1'b0;
        in_ch.mode       <= MODE_START;
        in_ch.data_block <= '0;
        in_ch.byte_count <= '0;
        row_none         <= 1'b0;
        i_rst_n          <= 1'b0;
        for (int k = 0; k < NUM_WORDS; k++) sponge_w[k] = '0;
        sponge_squeezing = 1'b0;
        gen_squeezing    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[k])
            feed(dir_rows[k].mode, dir_rows[k].data, dir_rows[k].count, dir_rows[k].none);
        fed      = 0;
        dir_done = 1'b1;
        while (fed < RANDOM_WORDS) random_message();
        in_ch.valid <= 1'b0;
        while (squeeze_words_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (squeeze_words_q.size() != 0) begin
            fail_count += squeeze_words_q.size();
            $display("%0d squeeze words never arrived", squeeze_words_q.size());
        end
        if (fail_count == 0) begin
            $display("ascon_xof_sponge_top_tb passed");
        end else begin
            $display("ascon_xof_sponge_top_tb failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/ascon_xs_pkg.sv
design/ascon_xs_in_if.sv
design/ascon_xs_out_if.sv
design/ascon_xof_sponge_top.sv
verif/ascon_xof_sponge_top_tb.sv
